/* sv/ddays_pkg.sv */
// Shared types, constants and calendar tables for the date difference block.
`default_nettype none
package ddays_pkg;

  localparam int MAX_YEAR   = 9999;
  localparam int DAY_W      = 5;
  localparam int MON_W      = 4;
  localparam int YEAR_W     = 14;
  localparam int DIST_W     = 22;
  // Day numbers reach about six million for any 14-bit year.
  localparam int DNUM_W     = 23;
  // Width of the intra-year and leap-day correction sum.
  localparam int FRAC_W     = 13;
  // Quotient of a 14-bit year by 100.
  localparam int YQ_W       = 8;
  localparam int DAYS_YEAR  = 365;

  // Division by 100 as a multiply by ceil(2^19 / 100), exact below 43690.
  localparam int DIV100_MUL = 5243;
  localparam int DIV100_SH  = 19;
  localparam int DIV_PROD_W = DIV100_SH + YQ_W;

  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic [MON_W-1:0] MON_JAN = MON_W'(1);
  localparam logic [MON_W-1:0] MON_FEB = MON_W'(2);
  localparam logic [MON_W-1:0] MON_DEC = MON_W'(12);
  localparam logic [DAY_W-1:0] FEB_LEAP_DAY = DAY_W'(29);

  typedef struct packed {
    logic [DAY_W-1:0]  first_day;
    logic [MON_W-1:0]  first_month;
    logic [YEAR_W-1:0] first_year;
    logic [DAY_W-1:0]  second_day;
    logic [MON_W-1:0]  second_month;
    logic [YEAR_W-1:0] second_year;
  } in_t;

  typedef struct packed {
    logic              date_error;
    logic [DIST_W-1:0] day_distance;
  } out_t;

  // One date after the front end has checked it and divided by 100.
  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic [MON_W-1:0]  month;
    logic [DAY_W-1:0]  day;
    logic [YQ_W-1:0]   year_q100;
    logic [YQ_W-1:0]   prev_q100;
    logic              base_ok;
    logic              need_leap;
  } date_cls_t;

  typedef struct packed {
    date_cls_t first;
    date_cls_t second;
  } item_cls_t;

  // Partial day number of one date.
  typedef struct packed {
    logic [DNUM_W-1:0] year_days;
    logic [FRAC_W-1:0] frac_days;
    logic              ok;
  } date_part_t;

  // Length of a month in a common year.
  function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m);
    logic [DAY_W-1:0] len;
    case (m)
      4'd2:                      len = DAY_W'(28);
      4'd4, 4'd6, 4'd9, 4'd11:   len = DAY_W'(30);
      4'd1, 4'd3, 4'd5, 4'd7,
      4'd8, 4'd10, 4'd12:        len = DAY_W'(31);
      default:                   len = '0;
    endcase
    return len;
  endfunction

  // Days of a common year that lie before the first of the month.
  function automatic logic [8:0] days_before(input logic [MON_W-1:0] m);
    logic [8:0] n;
    case (m)
      4'd1:    n = 9'd0;
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

/* sv/ddays_front.sv */
// Front end: checks both dates and divides their years by 100 ahead of the queue.
`default_nettype none
module ddays_front (
  input  wire ddays_pkg::in_t       in_data,
  output ddays_pkg::item_cls_t      cls
);

  function automatic ddays_pkg::date_cls_t classify(
    input logic [ddays_pkg::DAY_W-1:0]  d,
    input logic [ddays_pkg::MON_W-1:0]  m,
    input logic [ddays_pkg::YEAR_W-1:0] y
  );
    ddays_pkg::date_cls_t              c;
    logic [ddays_pkg::YEAR_W-1:0]      p;
    logic [ddays_pkg::DIV_PROD_W-1:0]  prod_y;
    logic [ddays_pkg::DIV_PROD_W-1:0]  prod_p;
    logic                              year_ok;
    logic                              month_ok;
    logic                              day_ok;
    p        = y - ddays_pkg::YEAR_W'(1);
    prod_y   = ddays_pkg::DIV_PROD_W'(y) * ddays_pkg::DIV_PROD_W'(ddays_pkg::DIV100_MUL);
    prod_p   = ddays_pkg::DIV_PROD_W'(p) * ddays_pkg::DIV_PROD_W'(ddays_pkg::DIV100_MUL);
    year_ok  = (y != '0) && (32'(y) <= 32'(ddays_pkg::MAX_YEAR));
    month_ok = (m >= ddays_pkg::MON_JAN) && (m <= ddays_pkg::MON_DEC);
    c.need_leap = (m == ddays_pkg::MON_FEB) && (d == ddays_pkg::FEB_LEAP_DAY);
    day_ok   = (d != '0) && ((d <= ddays_pkg::month_len(m)) || c.need_leap);
    c.year      = y;
    c.month     = m;
    c.day       = d;
    c.year_q100 = prod_y[ddays_pkg::DIV100_SH +: ddays_pkg::YQ_W];
    c.prev_q100 = prod_p[ddays_pkg::DIV100_SH +: ddays_pkg::YQ_W];
    c.base_ok   = year_ok && month_ok && day_ok;
    return c;
  endfunction

  assign cls.first  = classify(in_data.first_day, in_data.first_month, in_data.first_year);
  assign cls.second = classify(in_data.second_day, in_data.second_month,
                               in_data.second_year);

endmodule
`default_nettype wire

/* sv/ddays_queue.sv */
// Short queue of classified beats between the front end and the back end.
`default_nettype none
module ddays_queue (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        push,
  input  wire ddays_pkg::item_cls_t  wr_data,
  output logic                       full,
  input  wire                        pop,
  output logic                       rd_valid,
  output ddays_pkg::item_cls_t       rd_data
);

  ddays_pkg::item_cls_t              entries_r [ddays_pkg::QDEPTH];
  logic [ddays_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [ddays_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [ddays_pkg::QCNT_W-1:0]      count_r, count_nxt;

  assign full     = (count_r == ddays_pkg::QCNT_W'(ddays_pkg::QDEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + ddays_pkg::QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + ddays_pkg::QPTR_W'(1) : rd_ptr_r;
    case ({push, pop})
      2'b10:   count_nxt = count_r + ddays_pkg::QCNT_W'(1);
      2'b01:   count_nxt = count_r - ddays_pkg::QCNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

/* sv/ddays_back.sv */
// Back end: leap test, day numbers, absolute difference and output register.
`default_nettype none
module ddays_back (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        q_valid,
  input  wire ddays_pkg::item_cls_t  q_data,
  output logic                       q_pop,
  output logic                       out_valid,
  input  wire                        out_stall,
  output ddays_pkg::out_t            out_data
);

  function automatic ddays_pkg::date_part_t part_days(input ddays_pkg::date_cls_t c);
    ddays_pkg::date_part_t             r;
    logic [ddays_pkg::YEAR_W-1:0]      p;
    logic [ddays_pkg::YEAR_W:0]        yq100;
    logic                              leap;
    p     = c.year - ddays_pkg::YEAR_W'(1);
    yq100 = ((ddays_pkg::YEAR_W+1)'(c.year_q100) << 6)
          + ((ddays_pkg::YEAR_W+1)'(c.year_q100) << 5)
          + ((ddays_pkg::YEAR_W+1)'(c.year_q100) << 2);
    // Divisible by 4, and either not by 100 or else by 400.
    leap  = (c.year[1:0] == 2'b00) &&
            ((yq100 != (ddays_pkg::YEAR_W+1)'(c.year)) || (c.year_q100[1:0] == 2'b00));
    r.ok  = c.base_ok && (!c.need_leap || leap);
    r.year_days = ddays_pkg::DNUM_W'(p) * ddays_pkg::DNUM_W'(ddays_pkg::DAYS_YEAR);
    r.frac_days = ddays_pkg::FRAC_W'(p >> 2)
                + ddays_pkg::FRAC_W'(c.prev_q100 >> 2)
                - ddays_pkg::FRAC_W'(c.prev_q100)
                + ddays_pkg::FRAC_W'(ddays_pkg::days_before(c.month))
                + ddays_pkg::FRAC_W'(leap && (c.month > ddays_pkg::MON_FEB))
                + ddays_pkg::FRAC_W'(c.day);
    return r;
  endfunction

  logic                              adv;
  logic                              s1_valid_r;
  ddays_pkg::date_part_t             s1_a_r, s1_b_r;
  logic                              s2_valid_r;
  logic                              s2_err_r;
  logic [ddays_pkg::DNUM_W-1:0]      s2_a_r, s2_b_r;
  logic                              out_valid_r;
  ddays_pkg::out_t                   out_data_r, out_data_nxt;

  // The whole pipe moves together whenever the output register can take a beat.
  assign adv   = !out_valid_r || !out_stall;
  assign q_pop = adv && q_valid;

  always_comb begin
    out_data_nxt.date_error = s2_err_r;
    if (s2_err_r) begin
      out_data_nxt.day_distance = '0;
    end else if (s2_a_r > s2_b_r) begin
      out_data_nxt.day_distance = ddays_pkg::DIST_W'(s2_a_r - s2_b_r);
    end else begin
      out_data_nxt.day_distance = ddays_pkg::DIST_W'(s2_b_r - s2_a_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= q_valid;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_a_r     <= part_days(q_data.first);
      s1_b_r     <= part_days(q_data.second);
      s2_a_r     <= s1_a_r.year_days + ddays_pkg::DNUM_W'(s1_a_r.frac_days);
      s2_b_r     <= s1_b_r.year_days + ddays_pkg::DNUM_W'(s1_b_r.frac_days);
      s2_err_r   <= !(s1_a_r.ok && s1_b_r.ok);
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

/* sv/date_difference_in_days.sv */
// An accepted beat passes through the queue, then the s1, s2 and output registers.
// Throughput: one pair of dates per cycle unless the output is stalled; the year
// division by 100 is a constant multiply in the front end and the day numbers come
// from a three-stage back end. A four-entry queue keeps accepting in output stalls.
// Reset is synchronous and active low; it empties the queue and the pipeline.
`default_nettype none
module date_difference_in_days (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_stall,
  input  wire ddays_pkg::in_t    in_data,
  output logic                   out_valid,
  input  wire                    out_stall,
  output ddays_pkg::out_t        out_data
);

  ddays_pkg::item_cls_t  cls;
  ddays_pkg::item_cls_t  q_data;
  logic                  q_full;
  logic                  q_valid;
  logic                  q_pop;
  logic                  push;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  ddays_front u_front (
    .in_data (in_data),
    .cls     (cls)
  );

  ddays_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_data  (cls),
    .full     (q_full),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_data  (q_data)
  );

  ddays_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
